// ----- design/dbp_pkg.sv -----
// ----------------------------------------------------------------------------
// dbp_pkg
// Shared widths, register indexes, reset values and pipeline control type
// for the depth-to-point back-projection block.
// ----------------------------------------------------------------------------
package dbp_pkg;

	// field widths
	localparam int DEPTH_W    = 16;
	localparam int Z_W        = 15;
	localparam int INV_W      = 24;
	localparam int CTR_W      = 20;
	localparam int POINT_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// number of pipeline stages
	localparam int NSTG = 5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] IDX_INV_FOCAL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_INV_FOCAL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_CENTER_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_CENTER_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] IDX_MAX_DEPTH   = 3'd4;

	// register reset values
	localparam logic [INV_W-1:0] RST_INV_FOCAL = 24'd29177;
	localparam logic [CTR_W-1:0] RST_CENTER_X  = 20'd81920;
	localparam logic [CTR_W-1:0] RST_CENTER_Y  = 20'd61440;
	localparam logic [Z_W-1:0]   RST_MAX_DEPTH = 15'd32767;

	// saturation limits
	localparam logic [POINT_W-1:0] POINT_MAX = 32'h7FFF_FFFF;
	localparam logic [POINT_W-1:0] POINT_MIN = 32'h8000_0000;

	// per-stage load enables, bit k loads stage k+1
	typedef struct packed {
		logic [NSTG-1:0] en;
	} pipe_ctl_t;

endpackage

// ----- design/dbp_pixel_if.sv -----
// ----------------------------------------------------------------------------
// dbp_pixel_if
// Depth pixel channel: valid/ready with depth sample and pixel position.
// ----------------------------------------------------------------------------
interface dbp_pixel_if #(
	parameter int COORD_BITS = 12
) ();
	logic                    valid;
	logic                    ready;
	logic signed [15:0]      depth;
	logic [COORD_BITS-1:0]   column;
	logic [COORD_BITS-1:0]   row;

	modport source (output valid, depth, column, row, input ready);
	modport sink (input valid, depth, column, row, output ready);
endinterface

// ----- design/dbp_point_if.sv -----
// ----------------------------------------------------------------------------
// dbp_point_if
// Camera point channel: valid/ready with X, Y, Z and range flag.
// ----------------------------------------------------------------------------
interface dbp_point_if ();
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [14:0]        point_z;
	logic               valid_res;

	modport source (output valid, point_x, point_y, point_z, valid_res, input ready);
	modport sink (input valid, point_x, point_y, point_z, valid_res, output ready);
endinterface

// ----- design/depth_to_point_backprojection.sv -----
// ----------------------------------------------------------------------------
// depth_to_point_backprojection
// Pinhole back-projection of a depth pixel stream to camera-space points.
//
//   channel   dir  handshake      payload
//   pixel     in   valid/ready    depth, column, row
//   point     out  valid/ready    point_x, point_y, point_z, valid_res
//   cfg       in   cfg_write      cfg_index, cfg_data
//
// Five pipeline stages: offset, depth multiply, two partial products with the
// inverse focal length, round, saturate. One pixel enters per cycle unless every
// stage is full under an output stall. Reset clears the valid bits and loads the
// register defaults. An output stall fills empty stages first and then holds
// the pipeline; pixel.ready drops only when every stage is occupied.
// ----------------------------------------------------------------------------
module depth_to_point_backprojection #(
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dbp_pixel_if.sink                      pixel,
	dbp_point_if.source                    point,
	input  logic                           cfg_write,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dbp_pkg::*;

	logic [INV_W-1:0]   inv_focal_x_q, inv_focal_y_q;
	logic [CTR_W-1:0]   center_x_q, center_y_q;
	logic [Z_W-1:0]     max_depth_q;
	pipe_ctl_t          ctl;
	logic               in_ok;
	logic [POINT_W-1:0] res_x, res_y;

	logic               ok_s1, ok_s2, ok_s3, ok_s4, ok_s5;
	logic [Z_W-1:0]     z_s1, z_s2, z_s3, z_s4, z_s5;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_focal_x_q <= RST_INV_FOCAL;
			inv_focal_y_q <= RST_INV_FOCAL;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			max_depth_q   <= RST_MAX_DEPTH;
		end else if (cfg_write) begin
			unique case (cfg_index)
				IDX_INV_FOCAL_X: inv_focal_x_q <= cfg_data[INV_W-1:0];
				IDX_INV_FOCAL_Y: inv_focal_y_q <= cfg_data[INV_W-1:0];
				IDX_CENTER_X:    center_x_q    <= cfg_data[CTR_W-1:0];
				IDX_CENTER_Y:    center_y_q    <= cfg_data[CTR_W-1:0];
				IDX_MAX_DEPTH:   max_depth_q   <= cfg_data[Z_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	dbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (point.valid),
		.out_ready (point.ready),
		.ctl       (ctl)
	);

	// range test: positive and below the limit
	assign in_ok = !pixel.depth[DEPTH_W-1] && (pixel.depth != '0)
		&& (pixel.depth[Z_W-1:0] < max_depth_q);

	// range flag and depth carried alongside the axis pipelines
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			ok_s1 <= in_ok;
			z_s1  <= pixel.depth[Z_W-1:0];
		end
		if (ctl.en[1]) begin
			ok_s2 <= ok_s1;
			z_s2  <= z_s1;
		end
		if (ctl.en[2]) begin
			ok_s3 <= ok_s2;
			z_s3  <= z_s2;
		end
		if (ctl.en[3]) begin
			ok_s4 <= ok_s3;
			z_s4  <= z_s3;
		end
		if (ctl.en[4]) begin
			ok_s5 <= ok_s4;
			z_s5  <= z_s4;
		end
	end

	// x and y axes
	dbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk    (clk),
		.ctl    (ctl),
		.depth  (pixel.depth[Z_W-1:0]),
		.coord  (pixel.column),
		.center (center_x_q),
		.inv    (inv_focal_x_q),
		.res    (res_x)
	);

	dbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk    (clk),
		.ctl    (ctl),
		.depth  (pixel.depth[Z_W-1:0]),
		.coord  (pixel.row),
		.center (center_y_q),
		.inv    (inv_focal_y_q),
		.res    (res_y)
	);

	// rejected samples give an all-zero point
	assign point.point_x   = ok_s5 ? res_x : '0;
	assign point.point_y   = ok_s5 ? res_y : '0;
	assign point.point_z   = ok_s5 ? z_s5 : '0;
	assign point.valid_res = ok_s5;
endmodule

// ----- design/dbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// dbp_ctrl
// Valid bits and per-stage load enables of the projection pipeline. A stage
// loads when it is empty or when the stage after it loads, so bubbles
// collapse under a stall and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dbp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output dbp_pkg::pipe_ctl_t ctl
);
	import dbp_pkg::*;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	// enable chain from the output back to the input
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign ctl.en    = en;
	assign in_ready  = en[0];
	assign out_valid = vld_q[NSTG-1];
endmodule

// ----- design/dbp_axis.sv -----
// ----------------------------------------------------------------------------
// dbp_axis
// One axis of the back-projection: offset from the principal point, depth
// times offset, times inverse focal length in two partial products, round to
// nearest with ties away from zero, then saturate to 32 bits signed Q.8.
// ----------------------------------------------------------------------------
module dbp_axis #(
	parameter int COORD_BITS = 12
) (
	input  logic                          clk,
	input  dbp_pkg::pipe_ctl_t            ctl,
	input  logic [dbp_pkg::Z_W-1:0]       depth,
	input  logic [COORD_BITS-1:0]         coord,
	input  logic [dbp_pkg::CTR_W-1:0]     center,
	input  logic [dbp_pkg::INV_W-1:0]     inv,
	output logic [dbp_pkg::POINT_W-1:0]   res
);
	import dbp_pkg::*;

	localparam int POS_W  = COORD_BITS + 8;
	localparam int DIFF_W = (POS_W > CTR_W) ? POS_W : CTR_W;
	localparam int PROD_W = Z_W + DIFF_W;
	localparam int LO_W   = PROD_W / 2;
	localparam int HI_W   = PROD_W - LO_W;
	localparam int MAG_W  = PROD_W + INV_W + 1;
	localparam int Q_W    = MAG_W - INV_W;
	localparam logic [MAG_W-1:0] RND = MAG_W'(1) << (INV_W - 1);

	logic [DIFF_W-1:0]     pos;
	logic [DIFF_W-1:0]     ctr;
	logic [MAG_W-1:0]      mag;
	logic                  big;

	logic                  neg_s1, neg_s2, neg_s3, neg_s4;
	logic [DIFF_W-1:0]     diff_s1;
	logic [Z_W-1:0]        d_s1;
	logic [PROD_W-1:0]     prod_s2;
	logic [LO_W+INV_W-1:0] lo_s3;
	logic [HI_W+INV_W-1:0] hi_s3;
	logic [Q_W-1:0]        q_s4;
	logic [POINT_W-1:0]    res_s5;

	// stage 1: signed offset as sign and magnitude
	assign pos = DIFF_W'({coord, 8'd0});
	assign ctr = DIFF_W'(center);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			neg_s1  <= ctr > pos;
			diff_s1 <= (ctr > pos) ? (ctr - pos) : (pos - ctr);
			d_s1    <= depth;
		end
	end

	// stage 2: depth times offset
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			neg_s2  <= neg_s1;
			prod_s2 <= PROD_W'(d_s1) * PROD_W'(diff_s1);
		end
	end

	// stage 3: split product times inverse focal length
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			neg_s3 <= neg_s2;
			lo_s3  <= (LO_W+INV_W)'(prod_s2[LO_W-1:0]) * (LO_W+INV_W)'(inv);
			hi_s3  <= (HI_W+INV_W)'(prod_s2[PROD_W-1:LO_W]) * (HI_W+INV_W)'(inv);
		end
	end

	// stage 4: recombine, add half an lsb, drop the fraction
	assign mag = (MAG_W'(hi_s3) << LO_W) + MAG_W'(lo_s3) + RND;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			neg_s4 <= neg_s3;
			q_s4   <= mag[MAG_W-1:INV_W];
		end
	end

	// stage 5: apply sign and saturate
	assign big = |q_s4[Q_W-1:POINT_W-1];

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			if (neg_s4) begin
				res_s5 <= big ? POINT_MIN : (~q_s4[POINT_W-1:0] + POINT_W'(1));
			end else begin
				res_s5 <= big ? POINT_MAX : q_s4[POINT_W-1:0];
			end
		end
	end

	assign res = res_s5;
endmodule

// ----- dv/dbp_backprojection_checker.sv -----
// ----------------------------------------------------------------------------
// dbp_backprojection_checker
// Watches the pixel, point and register write ports of the back-projection
// block. It keeps its own copy of the camera registers, predicts the point for
// every pixel beat and compares each point beat with the oldest prediction.
// ----------------------------------------------------------------------------
module dbp_backprojection_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	dbp_pixel_if                           pixel,
	dbp_point_if                           point,
	input  logic                           cfg_write,
	input  logic [dbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbp_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             in_flight
);
	import dbp_pkg::*;

	typedef struct packed {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic [Z_W-1:0]            z;
		logic                      hit;
	} cam_point_t;

	// shadow of the camera registers
	logic [INV_W-1:0] fx_inv;
	logic [INV_W-1:0] fy_inv;
	logic [CTR_W-1:0] cx;
	logic [CTR_W-1:0] cy;
	logic [Z_W-1:0]   z_limit;

	cam_point_t expected_points[$];
	cam_point_t got;
	cam_point_t want;

	// one axis: depth times Q.8 offset times Q0.24 reciprocal, round, saturate
	function automatic logic signed [POINT_W-1:0] project_axis(
		logic [Z_W-1:0] mm, logic [15:0] coord, logic [CTR_W-1:0] ctr, logic [INV_W-1:0] inv
	);
		longint unsigned pos;
		longint unsigned cen;
		longint unsigned off;
		longint unsigned mag;
		longint unsigned q;
		logic            left;
		pos  = 64'(coord) << 8;
		cen  = 64'(ctr);
		left = cen > pos;
		off  = left ? cen - pos : pos - cen;
		mag  = 64'(mm) * off * 64'(inv);
		// round half away from zero on the magnitude
		q    = (mag + (64'd1 << 23)) >> 24;
		if (left) begin
			if (q >= 64'h8000_0000)
				return POINT_MIN;
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF)
			return POINT_MAX;
		return q[31:0];
	endfunction

	// full point for one pixel, zero point when the depth is out of range
	function automatic cam_point_t backproject(
		logic signed [DEPTH_W-1:0] d, logic [15:0] col, logic [15:0] row
	);
		cam_point_t     p;
		logic [Z_W-1:0] mm;
		p  = '0;
		mm = d[Z_W-1:0];
		if (d > 0 && mm < z_limit) begin
			p.x   = project_axis(mm, col, cx, fx_inv);
			p.y   = project_axis(mm, row, cy, fy_inv);
			p.z   = mm;
			p.hit = 1'b1;
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_inv     <= RST_INV_FOCAL;
			fy_inv     <= RST_INV_FOCAL;
			cx         <= RST_CENTER_X;
			cy         <= RST_CENTER_Y;
			z_limit    <= RST_MAX_DEPTH;
			in_flight  <= 0;
			mismatches = 0;
			expected_points.delete();
		end else begin
			// compare a point beat with the oldest prediction
			if (point.valid && point.ready) begin
				got = '{point.point_x, point.point_y, point.point_z, point.valid_res};
				if (expected_points.size() == 0) begin
					$error("point beat with no pixel waiting: x %0d y %0d z %0d",
						got.x, got.y, got.z);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x) begin
						$error("point_x: expected %0d, got %0d", want.x, got.x);
						mismatches++;
					end
					if (got.y !== want.y) begin
						$error("point_y: expected %0d, got %0d", want.y, got.y);
						mismatches++;
					end
					if (got.z !== want.z) begin
						$error("point_z: expected %0d, got %0d", want.z, got.z);
						mismatches++;
					end
					if (got.hit !== want.hit) begin
						$error("valid_res: expected %0d, got %0d", want.hit, got.hit);
						mismatches++;
					end
				end
			end
			// predict the point of a pixel beat
			if (pixel.valid && pixel.ready)
				expected_points.push_back(backproject(pixel.depth, 16'(pixel.column),
					16'(pixel.row)));
			in_flight <= in_flight + int'(pixel.valid && pixel.ready)
				- int'(point.valid && point.ready);
			// register writes, unmapped indexes dropped
			if (cfg_write) begin
				case (cfg_index)
					IDX_INV_FOCAL_X: fx_inv <= cfg_data[INV_W-1:0];
					IDX_INV_FOCAL_Y: fy_inv <= cfg_data[INV_W-1:0];
					IDX_CENTER_X:    cx <= cfg_data[CTR_W-1:0];
					IDX_CENTER_Y:    cy <= cfg_data[CTR_W-1:0];
					IDX_MAX_DEPTH:   z_limit <= cfg_data[Z_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- dv/tb_depth_to_point_backprojection.sv -----
// ----------------------------------------------------------------------------
// tb_depth_to_point_backprojection
// Drives depth pixels through the back-projection block under several camera
// settings: a directed set for range limits, rounding ties, saturation and
// masked or unmapped register writes, then random pixels under random
// settings. Both channels stall at random; the checker judges every point.
// ----------------------------------------------------------------------------
module tb_depth_to_point_backprojection;
	import dbp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT    = 23;

	typedef struct packed {
		logic signed [DEPTH_W-1:0] depth;
		logic [11:0]               column;
		logic [11:0]               row;
	} pixel_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  steady;
	int                    n_fail;
	int                    n_pending;
	int                    n_queued = 0;
	int                    n_sent = 0;
	int                    quiet_cycles;
	logic [Z_W-1:0]        cur_max_depth;
	pixel_beat_t           pixel_backlog[$];
	pixel_beat_t           beat;

	dbp_pixel_if #(.COORD_BITS(12)) pix ();
	dbp_point_if                    pnt ();

	depth_to_point_backprojection #(.COORD_BITS(12)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.point     (pnt),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dbp_backprojection_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel      (pix),
		.point      (pnt),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (n_fail),
		.in_flight  (n_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// pixel source: next beat once the current one is taken, random gaps
	initial begin
		pix.valid  = 1'b0;
		pix.depth  = '0;
		pix.column = '0;
		pix.row    = '0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				pix.valid <= 1'b0;
			end else begin
				if (pix.valid && pix.ready)
					n_sent <= n_sent + 1;
				if (!pix.valid || pix.ready) begin
					if (pixel_backlog.size() != 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
						beat = pixel_backlog.pop_front();
						pix.valid  <= 1'b1;
						pix.depth  <= beat.depth;
						pix.column <= beat.column;
						pix.row    <= beat.row;
					end else begin
						pix.valid <= 1'b0;
					end
				end
			end
		end
	end

	// point sink: random backpressure
	initial begin
		pnt.ready = 1'b0;
		forever begin
			@(posedge clk);
			pnt.ready <= steady || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// watchdog on cycles without any beat
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix.valid && pix.ready) || (pnt.valid && pnt.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("depth_to_point_backprojection regression: fail");
		$finish;
	end

	task automatic queue_pixel(input int d, input int c, input int r);
		pixel_backlog.push_back('{16'(d), 12'(c), 12'(r)});
		n_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == IDX_MAX_DEPTH)
			cur_max_depth = val[Z_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// wait for every pixel to be taken and every point to leave
	task automatic drain_pipe();
		do
			@(posedge clk);
		while (n_sent != n_queued || n_pending != 0);
		repeat (NSTG + 2) @(posedge clk);
	endtask

	function automatic logic [INV_W-1:0] pick_inv();
		case ($urandom_range(3))
			0: return 24'd1;
			1: return 24'hFF_FFFF;
			2: return 24'($urandom_range(1, 24'hFF_FFFF));
			default: return 24'($urandom_range(10000, 200000));
		endcase
	endfunction

	// center with random junk above the register width
	function automatic logic [CFG_DATA_W-1:0] pick_center();
		logic [CTR_W-1:0] c;
		case ($urandom_range(3))
			0: c = '0;
			1: c = 20'hF_FFFF;
			2: c = 20'($urandom);
			default: c = 20'($urandom_range(0, 4095 * 256));
		endcase
		return {4'($urandom), c};
	endfunction

	task automatic random_config();
		logic [Z_W-1:0] md;
		case ($urandom_range(9))
			0: md = '0;
			1: md = 15'd1;
			2: md = 15'h7FFF;
			default: md = 15'($urandom_range(64, 32767));
		endcase
		write_reg(IDX_INV_FOCAL_X, pick_inv());
		write_reg(IDX_INV_FOCAL_Y, pick_inv());
		write_reg(IDX_CENTER_X, pick_center());
		write_reg(IDX_CENTER_Y, pick_center());
		write_reg(IDX_MAX_DEPTH, {9'($urandom), md});
	endtask

	initial begin
		int md;
		int d;
		int r;
		arst_n        = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		steady        = 1'b0;
		cur_max_depth = RST_MAX_DEPTH;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: range limits, corners, zero offset
		@(negedge clk);
		queue_pixel(0, 320, 240);
		queue_pixel(-1, 0, 0);
		queue_pixel(-32768, 4095, 4095);
		queue_pixel(32767, 10, 10);
		queue_pixel(32766, 4095, 4095);
		queue_pixel(32766, 0, 0);
		queue_pixel(1, 320, 240);
		queue_pixel(1000, 4095, 0);
		queue_pixel(1000, 0, 4095);
		queue_pixel(16'h5555, 12'hAAA, 12'h555);
		queue_pixel(16'h2AAA, 12'h555, 12'hAAA);
		drain_pipe();

		// half-way ties on both sides of the center
		write_reg(IDX_INV_FOCAL_X, 24'h80_0000);
		write_reg(IDX_INV_FOCAL_Y, 24'h80_0000);
		write_reg(IDX_CENTER_X, 24'd257);
		write_reg(IDX_CENTER_Y, 24'd255);
		@(negedge clk);
		queue_pixel(1, 1, 1);
		queue_pixel(3, 1, 1);
		queue_pixel(1, 2, 0);
		queue_pixel(5, 0, 2);
		drain_pipe();

		// saturation, masked high bits, unmapped indexes ignored
		write_reg(IDX_INV_FOCAL_X, 24'hFF_FFFF);
		write_reg(IDX_INV_FOCAL_Y, 24'hFF_FFFF);
		write_reg(IDX_CENTER_X, 24'hFF_FFFF);
		write_reg(IDX_CENTER_Y, 24'h0);
		write_reg(IDX_MAX_DEPTH, 24'hFF_FFFF);
		for (int u = IDX_MAX_DEPTH + 1; u < 2 ** CFG_IDX_W; u++)
			write_reg(CFG_IDX_W'(u), 24'h0);
		@(negedge clk);
		queue_pixel(32766, 0, 4095);
		queue_pixel(32766, 4095, 0);
		queue_pixel(1, 0, 0);
		queue_pixel(-32768, 0, 0);
		drain_pipe();

		// zero inverse focal and zero depth limit
		write_reg(IDX_INV_FOCAL_X, 24'h0);
		write_reg(IDX_MAX_DEPTH, 24'h0);
		@(negedge clk);
		queue_pixel(100, 5, 5);
		queue_pixel(1, 0, 0);
		queue_pixel(32767, 4095, 4095);
		drain_pipe();
		write_reg(IDX_MAX_DEPTH, 24'd2);
		@(negedge clk);
		queue_pixel(1, 4095, 4095);
		queue_pixel(2, 4095, 4095);
		drain_pipe();

		// random settings, one phase without any stalls
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			@(negedge clk);
			steady = (ph == 3);
			md = int'(cur_max_depth);
			for (int k = 0; k < 100; k++) begin
				r = $urandom_range(99);
				if (r < 65)
					d = md > 1 ? $urandom_range(1, md - 1) : $urandom_range(1, 32767);
				else if (r < 80)
					d = md + $urandom_range(0, 2) - 1;
				else
					d = $urandom;
				queue_pixel(d, $urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			drain_pipe();
		end
		steady = 1'b0;

		if (n_fail == 0 && n_pending == 0)
			$display("depth_to_point_backprojection regression: pass");
		else
			$display("depth_to_point_backprojection regression: fail");
		$finish;
	end

endmodule
